>>> hdl/sorted_priority_queue_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// Included by the files that carry concurrent checks; depends on nothing.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package spq_pkg;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_CHK,
		S_PUSH_CMP,
		S_POP_WAIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic push_init;
		logic push_rd;
		logic shift_wr;
		logic write_new;
		logic pop_rd;
		logic pop_done;
		logic res_empty;
		logic res_full;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic at_head;
		logic shift;
	} sts_t;

endpackage

>>> hdl/spq_ctrl.sv
// Sequencer for the sorted priority queue: decodes requests and steps
// the insertion scan. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd,
	output logic          busy
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_POP) begin
						if (!sts.empty) state_nx = S_POP_WAIT;
					end else begin
						if (!sts.full) state_nx = S_PUSH_CHK;
					end
				end
			end
			S_PUSH_CHK: begin
				if (sts.at_head) state_nx = S_IDLE;
				else state_nx = S_PUSH_CMP;
			end
			S_PUSH_CMP: begin
				if (sts.shift) state_nx = S_PUSH_CHK;
				else state_nx = S_IDLE;
			end
			S_POP_WAIT: state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == REQ_POP) begin
						cmd.res_empty = sts.empty;
						cmd.pop_rd    = !sts.empty;
					end else begin
						cmd.res_full  = sts.full;
						cmd.push_init = !sts.full;
					end
				end
			end
			S_PUSH_CHK: begin
				cmd.write_new = sts.at_head;
				cmd.push_rd   = !sts.at_head;
			end
			S_PUSH_CMP: begin
				// held entry ranks lower: move it one slot toward the tail
				cmd.shift_wr  = sts.shift;
				cmd.write_new = !sts.shift;
			end
			S_POP_WAIT: cmd.pop_done = 1'b1;
			default:    busy = 1'b1;
		endcase
	end

endmodule

>>> hdl/spq_datapath.sv
// Entry memory, ring pointers, count and result registers of the queue.
// Depends on spq_pkg and sorted_priority_queue_macros.svh.
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module spq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cmd_t      cmd,
	input  logic        [15:0] task_id,
	input  logic signed [15:0] priority_req,
	output spq_pkg::sts_t      sts,
	output logic               done,
	output logic        [15:0] popped_task,
	output logic        [1:0]  status,
	output logic        [4:0]  entry_count
);
	import spq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;
	logic [31:0]   entry_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] count_q;
	logic          done_q;
	logic [15:0]   res_task_q;
	logic [1:0]    res_status_q;
	logic [4:0]    res_count_q;

	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW-1:0] rp;
	logic [AW-1:0] head_inc;
	logic [AW-1:0] raddr;
	logic [31:0]   wdata;
	logic          we;
	logic          rd_en;
	logic [CW-1:0] count_nx;
	logic [31:0]   count_ext;

	// ring position just past the last held entry
	assign tail_sum = (AW + 1)'(head_q) + (AW + 1)'(count_q);
	always_comb begin
		if (tail_sum >= (AW + 1)'(DEPTH)) tail = AW'(tail_sum - (AW + 1)'(DEPTH));
		else tail = tail_sum[AW-1:0];
	end

	assign rp       = (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	assign raddr = cmd.pop_rd ? head_q : rp;
	assign rd_en = cmd.pop_rd | cmd.push_rd;
	assign we    = cmd.shift_wr | cmd.write_new;
	assign wdata = cmd.shift_wr ? rdata_q : entry_q;

	always_ff @(posedge clk) begin
		if (we) mem[wp_q] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_comb begin
		count_nx = count_q;
		if (cmd.write_new) count_nx = count_q + CW'(1);
		else if (cmd.pop_done) count_nx = count_q - CW'(1);
	end

	assign count_ext = 32'(count_nx);

	always_ff @(posedge clk) begin
		if (cmd.push_init) begin
			entry_q <= {priority_req, task_id};
			wp_q    <= tail;
		end else if (cmd.shift_wr) begin
			wp_q <= rp;
		end
		if (cmd.push_init) k_q <= count_q;
		else if (cmd.shift_wr) k_q <= k_q - CW'(1);
		res_task_q   <= cmd.pop_done ? rdata_q[15:0] : 16'd0;
		res_status_q <= cmd.res_empty ? ST_EMPTY : (cmd.res_full ? ST_FULL : ST_DONE);
		res_count_q  <= count_ext[4:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cmd.pop_done) head_q <= head_inc;
			count_q <= count_nx;
			done_q  <= cmd.res_empty | cmd.res_full | cmd.write_new | cmd.pop_done;
		end
	end

	assign sts.empty   = (count_q == '0);
	assign sts.full    = (count_q == CW'(DEPTH));
	assign sts.at_head = (k_q == '0);
	assign sts.shift   = $signed(rdata_q[31:16]) < $signed(entry_q[31:16]);

	assign done        = done_q;
	assign popped_task = res_task_q;
	assign status      = res_status_q;
	assign entry_count = res_count_q;

	`SPQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "count above depth")
	`SPQ_ASSERT_IMP(a_empty_report, clk, arst_n, done_q && res_status_q == ST_EMPTY,
		count_q == '0 && res_task_q == 16'd0, "empty status with entries held")
	`SPQ_ASSERT_IMP(a_full_report, clk, arst_n, done_q && res_status_q == ST_FULL,
		count_q == CW'(DEPTH), "full status while not full")
	`SPQ_ASSERT_IMP(a_count_step, clk, arst_n, count_q != $past(count_q),
		$past(cmd.write_new) || $past(cmd.pop_done), "count moved without a request")

endmodule

>>> hdl/sorted_priority_queue.sv
// Sorted priority queue. A pop passes through S_POP_WAIT before its result strobe,
// an empty/full reject goes straight to it; a push first runs the single-port
// read/compare/write insertion scan from the tail toward the head.
// busy is low again in the cycle the result is shown; the receiver cannot stall.
// Asynchronous reset empties the queue; the entry memory is not cleared.
`timescale 1ns / 1ps

module sorted_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_type,
	input  logic        [15:0] task_id,
	input  logic signed [15:0] priority_req,
	output logic               busy,
	output logic               done,
	output logic        [15:0] popped_task,
	output logic        [1:0]  status,
	output logic        [4:0]  entry_count
);
	import spq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	spq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.task_id      (task_id),
		.priority_req (priority_req),
		.sts          (sts),
		.done         (done),
		.popped_task  (popped_task),
		.status       (status),
		.entry_count  (entry_count)
	);

endmodule
